// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every user names its clock clk_i and
// its active-low reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("list table assertion failed");

// Checks that a condition never holds.
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_PROP(lbl, !(expr))

`endif

// ----- rtl/ovl_pkg.sv -----
package ovl_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 6;
  localparam int IDX_W    = 6;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int ELEM_W   = 7;

  localparam logic [ELEM_W-1:0] NONE_CODE = ELEM_W'(64);

  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  index;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [ADDR_W-1:0] position;
    logic [ELEM_W-1:0] element;
    logic [CNT_W-1:0]  count;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- rtl/ovl_if.sv -----
interface ovl_in_if;
  import ovl_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VAL_W-1:0]  value;
  logic [IDX_W-1:0]  index;

  modport source (output valid, mode, value, index, input ready);
  modport sink (input valid, mode, value, index, output ready);
endinterface

interface ovl_out_if;
  import ovl_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [ADDR_W-1:0] position;
  logic [ELEM_W-1:0] element;
  logic [CNT_W-1:0]  count;

  modport source (output valid, status, found, position, element, count, input ready);
  modport sink (input valid, status, found, position, element, count, output ready);
endinterface

// ----- rtl/ovl_ram.sv -----
module ovl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ovl_seq.sv -----
`include "assert_macros.svh"

module ovl_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ovl_pkg::item_t              in_item_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output ovl_pkg::result_t            res_o,
  output ovl_pkg::ram_req_t           ram_o,
  input  logic [ovl_pkg::VAL_W-1:0]   ram_rdata_i
);
  import ovl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_ELEM  = 3'd3;
  localparam logic [2:0] S_ELCAP = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] tag_q, tag_d;
  item_t             item_q, item_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [ELEM_W-1:0] element_q, element_d;
  logic              hit;

  // A read issued in the previous cycle returns now and matches the value.
  assign hit = pend_q && (ram_rdata_i == item_q.value);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    pend_d      = pend_q;
    tag_d       = tag_q;
    item_d      = item_q;
    found_d     = found_q;
    pos_d       = pos_q;
    status_d    = status_q;
    element_d   = element_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = tag_q - ADDR_W'(1);
    ram_o.wdata = ram_rdata_i;
    ram_o.raddr = rd_ptr_q[ADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d   = in_item_i;
          rd_ptr_d = '0;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          pos_d    = '0;
          status_d = STAT_DONE;
          state_d  = S_FIND;
          if (in_item_i.mode == MODE_APPEND) begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              status_d = STAT_FULL;
            end else begin
              ram_o.we    = 1'b1;
              ram_o.waddr = count_q[ADDR_W-1:0];
              ram_o.wdata = in_item_i.value;
              count_d     = count_q + CNT_W'(1);
            end
          end
        end
      end

      S_FIND: begin
        if (hit) begin
          pend_d = 1'b0;
          if (item_q.mode == MODE_REMOVE) begin
            rd_ptr_d = CNT_W'(tag_q) + CNT_W'(1);
            state_d  = S_SHIFT;
          end else begin
            found_d = 1'b1;
            pos_d   = tag_q;
            state_d = S_ELEM;
          end
        end else if ((rd_ptr_q == count_q) && !pend_q) begin
          if (item_q.mode == MODE_REMOVE) begin
            status_d = STAT_ABSENT;
          end
          state_d = S_ELEM;
        end else if (rd_ptr_q < count_q) begin
          pend_d   = 1'b1;
          tag_d    = rd_ptr_q[ADDR_W-1:0];
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
      end

      S_SHIFT: begin
        // Entry tag_q moves down one place; the first match among the moved
        // entries is the new first position of the value.
        if (pend_q) begin
          ram_o.we = 1'b1;
          if (hit && !found_q) begin
            found_d = 1'b1;
            pos_d   = tag_q - ADDR_W'(1);
          end
        end
        if (rd_ptr_q < count_q) begin
          pend_d   = 1'b1;
          tag_d    = rd_ptr_q[ADDR_W-1:0];
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_ELEM;
          end
        end
      end

      S_ELEM: begin
        if (CNT_W'(item_q.index) < count_q) begin
          ram_o.raddr = ADDR_W'(item_q.index);
          state_d     = S_ELCAP;
        end else begin
          element_d = NONE_CODE;
          state_d   = S_RESP;
        end
      end

      S_ELCAP: begin
        element_d = ELEM_W'(ram_rdata_i);
        state_d   = S_RESP;
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q     <= tag_d;
    item_q    <= item_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
    element_q <= element_d;
  end

  assign res_o.status   = status_q;
  assign res_o.found    = found_q;
  assign res_o.position = pos_q;
  assign res_o.element  = element_q;
  assign res_o.count    = count_q;

  `ASSERT_PROP(a_count_in_range, count_q <= CNT_W'(CAPACITY))
  `ASSERT_PROP(a_write_in_list, ram_o.we |-> (CNT_W'(ram_o.waddr) <= count_q))
  `ASSERT_NEVER(a_idle_read_pending, (state_q == S_IDLE) && pend_q)
  `ASSERT_PROP(a_remove_shrinks, ((state_q == S_SHIFT) && (state_d == S_ELEM)) |=> (count_q == $past(count_q) - CNT_W'(1)))

endmodule

// ----- rtl/ordered_value_list_table.sv -----
// Channel  | Direction | Fields                                   | Handshake
// ---------+-----------+------------------------------------------+-------------
// in_i     | sink      | mode, value, index                       | valid/ready
// out_o    | source    | status, found, position, element, count  | valid/ready
//
// A transaction occupies the sequencer until its result is taken; the search
// reads one entry per cycle and a removal shifts the rest down one per cycle.
// Its result is held in an output register that drives out_o.
// Reset clears the entry count and the sequencer; the entry memory is not
// cleared, since only entries below the count are ever read.
// A waiting result lets one more transaction in, then in_i stalls until out_o drains.
module ordered_value_list_table (
  input logic       clk_i,
  input logic       rst_ni,
  ovl_in_if.sink    in_i,
  ovl_out_if.source out_o
);
  import ovl_pkg::*;

  item_t             in_item;
  result_t           res;
  ram_req_t          ram_req;
  logic [VAL_W-1:0]  ram_rdata;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_q;
  result_t           out_res_q;

  assign in_item.mode  = in_i.mode;
  assign in_item.value = in_i.value;
  assign in_item.index = in_i.index;

  // The sequencer owns all list bookkeeping; this level adds the entry memory and the
  // output register that decouples it from the downstream consumer.
  ovl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // The entries are kept in list order in one memory with a registered read.
  ovl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // A new result may enter when the register is empty or being emptied.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_res_q.status;
  assign out_o.found    = out_res_q.found;
  assign out_o.position = out_res_q.position;
  assign out_o.element  = out_res_q.element;
  assign out_o.count    = out_res_q.count;

endmodule
